[sv/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the bin packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BFB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bin packer check failed");
`define BFB_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bin packer check failed");
`else
`define BFB_ASSERT(label, clk, rst_n, prop)
`define BFB_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[sv/bfb_pkg.sv]
// Package with the shared types and constants of the bin packer.
`default_nettype none

package bfb_pkg;

  localparam int unsigned W_W = 16;

  localparam logic [W_W-1:0] CAP_RESET = 16'hFFFF;

  localparam logic [1:0] STATUS_PLACED = 2'd0;
  localparam logic [1:0] STATUS_OVER   = 2'd1;
  localparam logic [1:0] STATUS_NOFIT  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE
  } bfb_state_t;

  typedef struct packed {
    logic           found;
    logic [W_W-1:0] best;
    logic           was_used;
  } bfb_tok_t;

  typedef struct packed {
    logic           clr;
    logic [W_W-1:0] clr_val;
    logic           wr;
    logic [W_W-1:0] wr_val;
    logic [W_W-1:0] weight;
  } bfb_ctl_t;

endpackage

`default_nettype wire

[sv/bfb_cell.sv]
// One bin cell: holds a bin's remaining capacity and used flag, and refines the search token.
`default_nettype none

module bfb_cell
  import bfb_pkg::*;
#(
  parameter int unsigned IDX_W    = 6,
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bfb_ctl_t         ctl,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire bfb_tok_t         tok_in,
  input  wire logic [IDX_W-1:0] idx_in,
  output bfb_tok_t              tok_out,
  output logic [IDX_W-1:0]      idx_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [W_W-1:0]   rem_r;
  logic [W_W-1:0]   rem_nxt;
  logic             used_r;
  logic             used_nxt;
  bfb_tok_t         tok_r;
  bfb_tok_t         tok_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic             fits;
  logic [W_W-1:0]   after;
  logic             take;

  always_comb begin
    rem_nxt  = rem_r;
    used_nxt = used_r;
    if (ctl.clr) begin
      rem_nxt  = ctl.clr_val;
      used_nxt = 1'b0;
    end else if (ctl.wr && (wr_idx == MY_IDX)) begin
      rem_nxt  = ctl.wr_val;
      used_nxt = 1'b1;
    end
  end

  always_comb begin
    fits  = (rem_r >= ctl.weight);
    after = rem_r - ctl.weight;
    take  = fits && (!tok_in.found || (after < tok_in.best));
    if (take) begin
      tok_nxt.found    = 1'b1;
      tok_nxt.best     = after;
      tok_nxt.was_used = used_r;
      idx_nxt          = MY_IDX;
    end else begin
      tok_nxt = tok_in;
      idx_nxt = idx_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= CAP_RESET;
      used_r <= 1'b0;
    end else begin
      rem_r  <= rem_nxt;
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    idx_r <= idx_nxt;
  end

  assign tok_out = tok_r;
  assign idx_out = idx_r;

endmodule

`default_nettype wire

[sv/bfb_ctrl.sv]
// Sequencer, capacity register, bin counter and result register of the bin packer.
`default_nettype none

module bfb_ctrl
  import bfb_pkg::*;
#(
  parameter int unsigned NUM_BINS = 64,
  parameter int unsigned IDX_W    = 6,
  parameter int unsigned CNT_W    = 6,
  parameter int unsigned UC_W     = 7
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [W_W-1:0]   in_item_weight,
  input  wire logic             in_start_of_set,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [5:0]            out_bin_index,
  output logic [W_W-1:0]        out_bin_remaining,
  output logic [6:0]            out_bins_used,
  output logic [1:0]            out_status,
  input  wire logic             cfg_wr_en,
  input  wire logic [W_W-1:0]   cfg_wr_data,
  input  wire bfb_tok_t         tail_tok,
  input  wire logic [IDX_W-1:0] tail_idx,
  output bfb_ctl_t              ctl,
  output logic [IDX_W-1:0]      wr_idx
);

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_BINS - 1);

  bfb_state_t       state_r;
  bfb_state_t       state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [W_W-1:0]   cap_r;
  logic [W_W-1:0]   weight_r;
  logic [UC_W-1:0]  used_cnt_r;
  logic [UC_W-1:0]  used_after;
  logic             out_valid_r;
  logic [5:0]       out_idx_r;
  logic [W_W-1:0]   out_rem_r;
  logic [6:0]       out_used_r;
  logic [1:0]       out_status_r;
  logic             fresh_r;
  bfb_tok_t         hold_tok_r;
  logic [IDX_W-1:0] hold_idx_r;
  bfb_tok_t         dec_tok;
  logic [IDX_W-1:0] dec_idx;
  logic             accept;
  logic             slot_free;
  logic             commit;
  logic             over;
  logic             placed;
  logic [1:0]       status;
  logic [IDX_W+5:0] idx_ext;
  logic [UC_W+6:0]  used_ext;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SEARCH;
      ST_SEARCH: if (cnt_r == LAST_CNT) state_nxt = ST_DECIDE;
      ST_DECIDE: if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    dec_tok   = fresh_r ? tail_tok : hold_tok_r;
    dec_idx   = fresh_r ? tail_idx : hold_idx_r;
    in_ready  = (state_r == ST_IDLE);
    accept    = in_valid && in_ready;
    slot_free = !out_valid_r || out_ready;
    commit    = (state_r == ST_DECIDE) && slot_free;
    over      = (weight_r > cap_r);
    placed    = !over && dec_tok.found;
    if (over) begin
      status = STATUS_OVER;
    end else if (!dec_tok.found) begin
      status = STATUS_NOFIT;
    end else begin
      status = STATUS_PLACED;
    end
    used_after  = used_cnt_r + UC_W'(placed && !dec_tok.was_used);
    idx_ext     = {6'b0, dec_idx};
    used_ext    = {7'b0, used_after};
    ctl.clr     = accept && in_start_of_set;
    ctl.clr_val = cap_r;
    ctl.wr      = commit && placed;
    ctl.wr_val  = dec_tok.best;
    ctl.weight  = weight_r;
    wr_idx      = dec_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cap_r       <= CAP_RESET;
      used_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      fresh_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fresh_r <= (state_r == ST_SEARCH) && (cnt_r == LAST_CNT);
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == ST_SEARCH) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (ctl.clr) begin
        used_cnt_r <= '0;
      end else if (commit) begin
        used_cnt_r <= used_after;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      weight_r <= in_item_weight;
    end
    if (state_r == ST_DECIDE) begin
      hold_tok_r <= dec_tok;
      hold_idx_r <= dec_idx;
    end
    if (commit) begin
      out_idx_r    <= placed ? idx_ext[5:0] : 6'd0;
      out_rem_r    <= placed ? dec_tok.best : '0;
      out_used_r   <= used_ext[6:0];
      out_status_r <= status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_bin_index     = out_idx_r;
  assign out_bin_remaining = out_rem_r;
  assign out_bins_used     = out_used_r;
  assign out_status        = out_status_r;

endmodule

`default_nettype wire

[sv/best_fit_bin_packer_core.sv]
// Top level of the best-fit bin packer: sequencer and the row of bin cells.
//
//   channel   direction  handshake                 payload
//   in_       input      in_valid / in_ready       item_weight, start_of_set
//   out_      output     out_valid / out_ready     bin_index, bin_remaining, bins_used, status
//   cfg_      input      cfg_wr_en                 wr_data (bin capacity)
//
// The search token walks the cell row one cell per cycle, and a new request is taken only
// once the previous one has been decided and its result committed. Reset clears every bin.
// A waiting result holds the next result back until it is taken; the next request is
// already searched meanwhile.
`default_nettype none
`include "assert_macros.svh"

module best_fit_bin_packer_core
  import bfb_pkg::*;
#(
  parameter int unsigned NUM_BINS = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [W_W-1:0] in_item_weight,
  input  wire logic           in_start_of_set,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [5:0]          out_bin_index,
  output logic [W_W-1:0]      out_bin_remaining,
  output logic [6:0]          out_bins_used,
  output logic [1:0]          out_status,
  input  wire logic           cfg_wr_en,
  input  wire logic [W_W-1:0] cfg_wr_data
);

  localparam int unsigned IDX_W = $clog2(NUM_BINS);
  localparam int unsigned CNT_W = $clog2(NUM_BINS);
  localparam int unsigned UC_W  = $clog2(NUM_BINS + 1);

  bfb_ctl_t         ctl;
  logic [IDX_W-1:0] wr_idx;
  bfb_tok_t         tok [NUM_BINS+1];
  logic [IDX_W-1:0] idx [NUM_BINS+1];

  assign tok[0] = '0;
  assign idx[0] = '0;

  bfb_ctrl #(
    .NUM_BINS (NUM_BINS),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W),
    .UC_W     (UC_W)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_item_weight    (in_item_weight),
    .in_start_of_set   (in_start_of_set),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_bin_index     (out_bin_index),
    .out_bin_remaining (out_bin_remaining),
    .out_bins_used     (out_bins_used),
    .out_status        (out_status),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .tail_tok          (tok[NUM_BINS]),
    .tail_idx          (idx[NUM_BINS]),
    .ctl               (ctl),
    .wr_idx            (wr_idx)
  );

  for (genvar g = 0; g < NUM_BINS; g++) begin : g_cell
    bfb_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .wr_idx  (wr_idx),
      .tok_in  (tok[g]),
      .idx_in  (idx[g]),
      .tok_out (tok[g+1]),
      .idx_out (idx[g+1])
    );
  end

  `BFB_ASSERT(a_one_request, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
  `BFB_ASSERT(a_status_code, clk, rst_n, out_valid |-> (out_status <= STATUS_NOFIT))
  `BFB_ASSERT(a_fail_zero, clk, rst_n,
              (out_valid && out_status != STATUS_PLACED) |->
              (out_bin_index == 6'd0 && out_bin_remaining == '0))
  `BFB_ASSERT(a_no_clear_busy, clk, rst_n, !in_ready |-> !ctl.clr)

endmodule

`default_nettype wire
